>>> design/bir_pkg.sv
package bir_pkg;

    // Sizes of the frame store and of the arithmetic
    localparam int SRC_MAX_WIDTH  = 256;
    localparam int SRC_MAX_HEIGHT = 256;
    localparam int PIXEL_BITS     = 16;
    localparam int FRAC_BITS      = 16;
    localparam int DST_MAX        = 4096;

    localparam int COORD_BITS     = 12;
    localparam int SRC_CFG_BITS   = 9;
    localparam int DST_CFG_BITS   = 13;
    localparam int COL_BITS       = $clog2(SRC_MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(SRC_MAX_HEIGHT);
    localparam int NUM_BITS       = COORD_BITS + COL_BITS;
    localparam int Q_BITS         = COL_BITS + FRAC_BITS;
    localparam int REM_BITS       = DST_CFG_BITS - 1;
    localparam int BANK_ADDR_BITS = COL_BITS - 1 + ROW_BITS - 1;
    localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
    localparam int WEIGHT_BITS    = FRAC_BITS + 1;
    localparam int ROW_SUM_BITS   = PIXEL_BITS + FRAC_BITS;
    localparam int SUM_BITS       = PIXEL_BITS + 2 * FRAC_BITS;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic {
        ST_OK    = 1'b0,
        ST_RANGE = 1'b1
    } status_t;

    typedef struct packed {
        opcode_t                 opcode;
        logic [COORD_BITS-1:0]   coord_x;
        logic [COORD_BITS-1:0]   coord_y;
        logic [PIXEL_BITS-1:0]   pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0]   gray_out;
        logic [COORD_BITS-1:0]   out_x;
        logic [COORD_BITS-1:0]   out_y;
        status_t                 status;
    } out_item_t;

    // Divider pipeline payload
    typedef struct packed {
        opcode_t                 op;
        logic                    err;
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [PIXEL_BITS-1:0]   pix;
        logic [NUM_BITS-1:0]     numx;
        logic [NUM_BITS-1:0]     numy;
        logic [REM_BITS-1:0]     remx;
        logic [REM_BITS-1:0]     remy;
        logic [Q_BITS-1:0]       qx;
        logic [Q_BITS-1:0]       qy;
    } div_t;

    // Address stage payload
    typedef struct packed {
        opcode_t                      op;
        logic                         err;
        logic [COORD_BITS-1:0]        cx;
        logic [COORD_BITS-1:0]        cy;
        logic [PIXEL_BITS-1:0]        pix;
        logic [FRAC_BITS-1:0]         fx;
        logic [FRAC_BITS-1:0]         fy;
        logic [COL_BITS-1:0]          ix;
        logic [COL_BITS-1:0]          ix1;
        logic [ROW_BITS-1:0]          iy;
        logic [ROW_BITS-1:0]          iy1;
        logic [3:0]                   we;
        logic [3:0][BANK_ADDR_BITS-1:0] addr;
    } addr_t;

    // Memory read stage payload
    typedef struct packed {
        logic                    err;
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [FRAC_BITS-1:0]    fx;
        logic [FRAC_BITS-1:0]    fy;
        logic                    ixp;
        logic                    ix1p;
        logic                    iyp;
        logic                    iy1p;
    } mem_t;

    typedef struct packed {
        logic                    err;
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [FRAC_BITS-1:0]    fy;
        logic [ROW_SUM_BITS-1:0] top;
        logic [ROW_SUM_BITS-1:0] bot;
    } blend1_t;

    typedef struct packed {
        logic                    err;
        logic [COORD_BITS-1:0]   cx;
        logic [COORD_BITS-1:0]   cy;
        logic [SUM_BITS-1:0]     sum;
    } blend2_t;

endpackage

>>> design/bilinear_image_resizer_core.sv
// Channel   Signals                               Moves
// in        in_valid, in_ready, in_data           load pixel or query item
// out       out_valid, out_ready, out_data        one result per query
// cfg       cfg_valid, cfg_ready, cfg_index/data  register write, always ready
//
// One item enters per cycle unless the whole pipe holds. A query passes the
// entry stage, the two restoring dividers (one quotient bit per stage), the
// address, read, blend and output stages. Loads travel the same pipe and write
// the banked frame store at the read stage, so reads and writes stay in order.
// Reset clears the valid bits and the registers to 256; the frame store is not
// cleared. When the output register holds a result not taken, the pipe holds.
module bilinear_image_resizer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bir_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bir_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data
);
    import bir_pkg::*;

    logic [SRC_CFG_BITS-1:0] src_width_reg;
    logic [SRC_CFG_BITS-1:0] src_height_reg;
    logic [DST_CFG_BITS-1:0] dst_width_reg;
    logic [DST_CFG_BITS-1:0] dst_height_reg;

    logic [DST_CFG_BITS-1:0] dw_c;
    logic [DST_CFG_BITS-1:0] dh_c;
    logic [COL_BITS-1:0]     swm1;
    logic [ROW_BITS-1:0]     shm1;
    logic                    en;

    logic                    dv_vld_reg [0:Q_BITS];
    div_t                    dv_reg     [0:Q_BITS];
    div_t                    dv0_next;

    logic                    ad_vld_reg;
    addr_t                   ad_reg;
    addr_t                   ad_next;

    logic                    mm_vld_reg;
    mem_t                    mm_reg;
    logic [PIXEL_BITS-1:0]   rd_reg [0:3];

    logic                    b1_vld_reg;
    blend1_t                 b1_reg;
    blend1_t                 b1_next;
    logic                    b2_vld_reg;
    blend2_t                 b2_reg;
    blend2_t                 b2_next;

    logic                    out_vld_reg;
    out_item_t               out_reg;
    out_item_t               out_next;

    function automatic logic [REM_BITS:0] div_step(
        input logic [REM_BITS-1:0]     rem,
        input logic [NUM_BITS-1:0]     num,
        input logic [DST_CFG_BITS-1:0] d,
        input logic [5:0]              pos
    );
        logic [NUM_BITS+FRAC_BITS-1:0] n;
        logic [REM_BITS:0]             r2;
        logic [REM_BITS:0]             diff;
        n    = {num, {FRAC_BITS{1'b0}}};
        r2   = {rem, n[pos]};
        diff = r2 - d;
        if (r2 >= d) begin
            return {diff[REM_BITS-1:0], 1'b1};
        end
        return {r2[REM_BITS-1:0], 1'b0};
    endfunction

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            src_width_reg  <= SRC_CFG_BITS'(256);
            src_height_reg <= SRC_CFG_BITS'(256);
            dst_width_reg  <= DST_CFG_BITS'(256);
            dst_height_reg <= DST_CFG_BITS'(256);
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_CFG_BITS-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_CFG_BITS-1:0];
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                CFG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes into their legal ranges
    always_comb begin
        logic [SRC_CFG_BITS-1:0] sw;
        logic [SRC_CFG_BITS-1:0] sh;
        sw = src_width_reg;
        sh = src_height_reg;
        if (sw == '0) sw = SRC_CFG_BITS'(1);
        if (sw > SRC_CFG_BITS'(SRC_MAX_WIDTH)) sw = SRC_CFG_BITS'(SRC_MAX_WIDTH);
        if (sh == '0) sh = SRC_CFG_BITS'(1);
        if (sh > SRC_CFG_BITS'(SRC_MAX_HEIGHT)) sh = SRC_CFG_BITS'(SRC_MAX_HEIGHT);
        swm1 = COL_BITS'(sw - SRC_CFG_BITS'(1));
        shm1 = ROW_BITS'(sh - SRC_CFG_BITS'(1));
        dw_c = (dst_width_reg > DST_CFG_BITS'(DST_MAX)) ? DST_CFG_BITS'(DST_MAX)
                                                        : dst_width_reg;
        dh_c = (dst_height_reg > DST_CFG_BITS'(DST_MAX)) ? DST_CFG_BITS'(DST_MAX)
                                                         : dst_height_reg;
    end

    // Advance the whole pipe unless the output holds an untaken result
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // Entry stage: range check and numerator products
    always_comb begin
        dv0_next      = '0;
        dv0_next.op   = in_data.opcode;
        dv0_next.cx   = in_data.coord_x;
        dv0_next.cy   = in_data.coord_y;
        dv0_next.pix  = in_data.pixel_in;
        dv0_next.err  = ({1'b0, in_data.coord_x} >= dw_c)
                     || ({1'b0, in_data.coord_y} >= dh_c);
        dv0_next.numx = NUM_BITS'(in_data.coord_x) * NUM_BITS'(swm1);
        dv0_next.numy = NUM_BITS'(in_data.coord_y) * NUM_BITS'(shm1);
        dv0_next.remx = dv0_next.numx[NUM_BITS-1:COL_BITS];
        dv0_next.remy = dv0_next.numy[NUM_BITS-1:ROW_BITS];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            dv_reg[0] <= dv0_next;
        end
    end

    // Restoring dividers, one quotient bit per stage, MSB first
    for (genvar k = 0; k < Q_BITS; k++) begin : g_div
        localparam int B = Q_BITS - 1 - k;
        div_t nxt;

        always_comb begin
            nxt = dv_reg[k];
            {nxt.remx, nxt.qx[B]} = div_step(dv_reg[k].remx, dv_reg[k].numx, dw_c, 6'(B));
            {nxt.remy, nxt.qy[B]} = div_step(dv_reg[k].remy, dv_reg[k].numy, dh_c, 6'(B));
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                dv_reg[k+1] <= nxt;
            end
        end
    end

    // Address stage: neighbour indices and per-bank addresses
    always_comb begin
        div_t d;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        d           = dv_reg[Q_BITS];
        ad_next     = '0;
        ad_next.op  = d.op;
        ad_next.err = d.err;
        ad_next.cx  = d.cx;
        ad_next.cy  = d.cy;
        ad_next.pix = d.pix;
        ad_next.fx  = d.qx[FRAC_BITS-1:0];
        ad_next.fy  = d.qy[FRAC_BITS-1:0];
        ad_next.ix  = d.qx[Q_BITS-1:FRAC_BITS];
        ad_next.iy  = d.qy[Q_BITS-1:FRAC_BITS];
        ad_next.ix1 = (ad_next.ix < swm1) ? ad_next.ix + COL_BITS'(1) : swm1;
        ad_next.iy1 = (ad_next.iy < shm1) ? ad_next.iy + ROW_BITS'(1) : shm1;
        for (int b = 0; b < 4; b++) begin
            if (d.op == OP_LOAD) begin
                col = d.cx[COL_BITS-1:0];
                row = d.cy[ROW_BITS-1:0];
                ad_next.we[b] = (d.cx < COORD_BITS'(SRC_MAX_WIDTH))
                             && (d.cy < COORD_BITS'(SRC_MAX_HEIGHT))
                             && (d.cx[0] == b[0]) && (d.cy[0] == b[1]);
            end else begin
                col = (ad_next.ix[0] == b[0]) ? ad_next.ix : ad_next.ix1;
                row = (ad_next.iy[0] == b[1]) ? ad_next.iy : ad_next.iy1;
            end
            ad_next.addr[b] = {row[ROW_BITS-1:1], col[COL_BITS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ad_vld_reg <= 1'b0;
        end else if (en) begin
            ad_vld_reg <= dv_vld_reg[Q_BITS];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            ad_reg <= ad_next;
        end
    end

    // Frame store: four banks split by row and column parity
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIXEL_BITS-1:0] mem [0:BANK_DEPTH-1];

        always_ff @(posedge clk) begin
            if (en) begin
                if (ad_vld_reg && ad_reg.we[b]) begin
                    mem[ad_reg.addr[b]] <= ad_reg.pix;
                end
                rd_reg[b] <= mem[ad_reg.addr[b]];
            end
        end
    end

    // Drop loads after the store access
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mm_vld_reg <= 1'b0;
        end else if (en) begin
            mm_vld_reg <= ad_vld_reg && (ad_reg.op == OP_QUERY);
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mm_reg.err  <= ad_reg.err;
            mm_reg.cx   <= ad_reg.cx;
            mm_reg.cy   <= ad_reg.cy;
            mm_reg.fx   <= ad_reg.fx;
            mm_reg.fy   <= ad_reg.fy;
            mm_reg.ixp  <= ad_reg.ix[0];
            mm_reg.ix1p <= ad_reg.ix1[0];
            mm_reg.iyp  <= ad_reg.iy[0];
            mm_reg.iy1p <= ad_reg.iy1[0];
        end
    end

    // Horizontal blend of both rows
    always_comb begin
        logic [PIXEL_BITS-1:0]   p00;
        logic [PIXEL_BITS-1:0]   p10;
        logic [PIXEL_BITS-1:0]   p01;
        logic [PIXEL_BITS-1:0]   p11;
        logic [WEIGHT_BITS-1:0]  w1;
        logic [WEIGHT_BITS-1:0]  w0;
        logic [ROW_SUM_BITS:0]   t;
        logic [ROW_SUM_BITS:0]   u;
        p00 = rd_reg[{mm_reg.iyp,  mm_reg.ixp}];
        p10 = rd_reg[{mm_reg.iyp,  mm_reg.ix1p}];
        p01 = rd_reg[{mm_reg.iy1p, mm_reg.ixp}];
        p11 = rd_reg[{mm_reg.iy1p, mm_reg.ix1p}];
        w1  = WEIGHT_BITS'(mm_reg.fx);
        w0  = (WEIGHT_BITS'(1) << FRAC_BITS) - w1;
        t   = (ROW_SUM_BITS+1)'(p00) * (ROW_SUM_BITS+1)'(w0)
            + (ROW_SUM_BITS+1)'(p10) * (ROW_SUM_BITS+1)'(w1);
        u   = (ROW_SUM_BITS+1)'(p01) * (ROW_SUM_BITS+1)'(w0)
            + (ROW_SUM_BITS+1)'(p11) * (ROW_SUM_BITS+1)'(w1);
        b1_next.err = mm_reg.err;
        b1_next.cx  = mm_reg.cx;
        b1_next.cy  = mm_reg.cy;
        b1_next.fy  = mm_reg.fy;
        b1_next.top = t[ROW_SUM_BITS-1:0];
        b1_next.bot = u[ROW_SUM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b1_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg <= mm_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            b1_reg <= b1_next;
        end
    end

    // Vertical blend
    always_comb begin
        logic [WEIGHT_BITS-1:0] w1;
        logic [WEIGHT_BITS-1:0] w0;
        logic [SUM_BITS:0]      s;
        w1 = WEIGHT_BITS'(b1_reg.fy);
        w0 = (WEIGHT_BITS'(1) << FRAC_BITS) - w1;
        s  = (SUM_BITS+1)'(b1_reg.top) * (SUM_BITS+1)'(w0)
           + (SUM_BITS+1)'(b1_reg.bot) * (SUM_BITS+1)'(w1);
        b2_next.err = b1_reg.err;
        b2_next.cx  = b1_reg.cx;
        b2_next.cy  = b1_reg.cy;
        b2_next.sum = s[SUM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b2_vld_reg <= 1'b0;
        end else if (en) begin
            b2_vld_reg <= b1_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            b2_reg <= b2_next;
        end
    end

    // Round half up, saturate, flag range errors
    always_comb begin
        logic [SUM_BITS:0]     rnd;
        logic [PIXEL_BITS:0]   val;
        rnd = (SUM_BITS+1)'(b2_reg.sum) + ((SUM_BITS+1)'(1) << (2 * FRAC_BITS - 1));
        val = rnd[SUM_BITS:2*FRAC_BITS];
        out_next.out_x = b2_reg.cx;
        out_next.out_y = b2_reg.cy;
        if (b2_reg.err) begin
            out_next.gray_out = '0;
            out_next.status   = ST_RANGE;
        end else begin
            out_next.gray_out = val[PIXEL_BITS] ? {PIXEL_BITS{1'b1}}
                                                : val[PIXEL_BITS-1:0];
            out_next.status   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= b2_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // Checks
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_reg.status == ST_RANGE) |-> out_reg.gray_out == '0)
        else $error("range error result carries nonzero gray");

    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        ad_vld_reg |-> $onehot0(ad_reg.we))
        else $error("load writes more than one bank");

    a_neighbour_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        ad_vld_reg && (ad_reg.op == OP_QUERY) && !ad_reg.err
            |-> (ad_reg.ix1 <= swm1) && (ad_reg.iy1 <= shm1)
                && (ad_reg.ix <= swm1) && (ad_reg.iy <= shm1))
        else $error("neighbour index beyond source size");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(b2_vld_reg))
        else $error("result appeared without a blended item");

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bir_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    bilinear_image_resizer_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [15:0] src_pix [0:65535];
    bit          pix_written [0:65535];
    int unsigned reg_src_w = 256, reg_src_h = 256, reg_dst_w = 256, reg_dst_h = 256;

    out_item_t   pending_results [$];
    int          fail_count = 0;
    int          hold_cycles = 0;
    int          long_hold_req = 0;
    int          long_hold_ack = 0;
    bit          stall_enable = 1'b1;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Work out the result of a query against the current frame and sizes
    function automatic out_item_t resize_pixel(input in_item_t it);
        out_item_t r;
        longint unsigned sw, sh, dw, dh, gx, gy, ix, iy, ix1, iy1, fx, fy;
        longint unsigned p00, p10, p01, p11, top, bot, sum, val;
        r.out_x = it.coord_x;
        r.out_y = it.coord_y;
        dw = (reg_dst_w > DST_MAX) ? DST_MAX : reg_dst_w;
        dh = (reg_dst_h > DST_MAX) ? DST_MAX : reg_dst_h;
        if (it.coord_x >= dw || it.coord_y >= dh) begin
            r.gray_out = '0;
            r.status = ST_RANGE;
            return r;
        end
        sw = (reg_src_w == 0) ? 1 : (reg_src_w > SRC_MAX_WIDTH) ? SRC_MAX_WIDTH : reg_src_w;
        sh = (reg_src_h == 0) ? 1 : (reg_src_h > SRC_MAX_HEIGHT) ? SRC_MAX_HEIGHT : reg_src_h;
        gx = ((longint'(it.coord_x) * (sw - 1)) << FRAC_BITS) / dw;
        gy = ((longint'(it.coord_y) * (sh - 1)) << FRAC_BITS) / dh;
        ix = gx >> FRAC_BITS;
        iy = gy >> FRAC_BITS;
        fx = gx & 64'hFFFF;
        fy = gy & 64'hFFFF;
        ix1 = (ix + 1 < sw) ? ix + 1 : sw - 1;
        iy1 = (iy + 1 < sh) ? iy + 1 : sh - 1;
        p00 = src_pix[iy * 256 + ix];
        p10 = src_pix[iy * 256 + ix1];
        p01 = src_pix[iy1 * 256 + ix];
        p11 = src_pix[iy1 * 256 + ix1];
        top = p00 * (65536 - fx) + p10 * fx;
        bot = p01 * (65536 - fx) + p11 * fx;
        sum = top * (65536 - fy) + bot * fy;
        val = (sum + (64'd1 << 31)) >> 32;
        if (val > 65535) val = 65535;
        r.gray_out = val[15:0];
        r.status = ST_OK;
        return r;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(input in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        if (it.opcode == OP_LOAD) begin
            if (it.coord_x < 256 && it.coord_y < 256) begin
                src_pix[it.coord_y * 256 + it.coord_x] = it.pixel_in;
                pix_written[it.coord_y * 256 + it.coord_x] = 1'b1;
            end
        end else begin
            pending_results.push_back(resize_pixel(it));
        end
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0) in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic in_item_t load_item(input int x, input int y, input int p);
        in_item_t it;
        it.opcode = OP_LOAD;
        it.coord_x = 12'(x);
        it.coord_y = 12'(y);
        it.pixel_in = 16'(p);
        return it;
    endfunction

    // Query that only reads written pixels, or lands out of range
    function automatic bit query_safe(input in_item_t it);
        int unsigned sw, sh, dw, dh, ix, iy, ix1, iy1;
        dw = (reg_dst_w > DST_MAX) ? DST_MAX : reg_dst_w;
        dh = (reg_dst_h > DST_MAX) ? DST_MAX : reg_dst_h;
        if (it.coord_x >= dw || it.coord_y >= dh) return 1'b1;
        sw = (reg_src_w == 0) ? 1 : (reg_src_w > 256) ? 256 : reg_src_w;
        sh = (reg_src_h == 0) ? 1 : (reg_src_h > 256) ? 256 : reg_src_h;
        ix = 32'(((longint'(it.coord_x) * (sw - 1)) << 16) / dw >> 16);
        iy = 32'(((longint'(it.coord_y) * (sh - 1)) << 16) / dh >> 16);
        ix1 = (ix + 1 < sw) ? ix + 1 : sw - 1;
        iy1 = (iy + 1 < sh) ? iy + 1 : sh - 1;
        return pix_written[iy*256+ix] && pix_written[iy*256+ix1] &&
               pix_written[iy1*256+ix] && pix_written[iy1*256+ix1];
    endfunction

    function automatic in_item_t query_item(input int x, input int y);
        in_item_t it;
        it.opcode = OP_QUERY;
        it.coord_x = 12'(x);
        it.coord_y = 12'(y);
        it.pixel_in = 16'($urandom);
        return it;
    endfunction

    // Drain, let the pipe empty, then write one register
    task automatic write_reg(input cfg_index_t idx, input int value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:  reg_src_w = value & 9'h1FF;
            CFG_SRC_HEIGHT: reg_src_h = value & 9'h1FF;
            CFG_DST_WIDTH:  reg_dst_w = value & 13'h1FFF;
            default:        reg_dst_h = value & 13'h1FFF;
        endcase
    endtask

    task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
    endtask

    // Fill the top-left source region that the current sizes can touch
    task automatic fill_source(input bit extremes);
        int sw, sh, p;
        sw = (reg_src_w == 0) ? 1 : (reg_src_w > 256) ? 256 : reg_src_w;
        sh = (reg_src_h == 0) ? 1 : (reg_src_h > 256) ? 256 : reg_src_h;
        for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++) begin
                p = extremes ? (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000) : $urandom;
                send_item(load_item(x, y, p));
                if ($urandom_range(0, 7) == 0) random_gap();
            end
    endtask

    task automatic test_directed();
        // small source, every pixel at a value extreme
        set_sizes(3, 2, 7, 5);
        fill_source(1'b1);
        send_item(query_item(0, 0));
        send_item(query_item(6, 4));
        send_item(query_item(3, 2));
        // query outside destination, in each direction and at field max
        send_item(query_item(7, 0));
        send_item(query_item(0, 5));
        send_item(query_item(4095, 4095));
        // loads outside the store are dropped
        send_item(load_item(256, 0, 16'h1234));
        send_item(load_item(0, 4095, 16'hABCD));
        send_item(load_item(4095, 256, 16'hFFFF));
        // zero and oversize sizes
        set_sizes(0, 511, 4096, 8191);
        send_item(query_item(0, 0));
        send_item(query_item(4095, 1));
        write_reg(CFG_DST_WIDTH, 0);
        send_item(query_item(0, 0));
        set_sizes(1, 1, 1, 1);
        send_item(query_item(0, 0));
    endtask

    // Random phases over size settings, mostly valid queries
    task automatic test_random_phase(input int sw, input int sh, input int dw, input int dh,
                                     input int count);
        in_item_t it;
        int dwc, dhc;
        set_sizes(sw, sh, dw, dh);
        fill_source(1'b0);
        dwc = (reg_dst_w > 4096) ? 4096 : reg_dst_w;
        dhc = (reg_dst_h > 4096) ? 4096 : reg_dst_h;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: it = query_item($urandom_range(0, 4095), $urandom_range(0, 4095));
                1: it = load_item($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
                2: it = query_item((dwc > 0) ? dwc - 1 : 0, (dhc > 0) ? dhc - 1 : 0);
                default: it = query_item($urandom_range(0, (dwc > 0) ? dwc - 1 : 0),
                                         $urandom_range(0, (dhc > 0) ? dhc - 1 : 0));
            endcase
            if (it.opcode == OP_QUERY && !query_safe(it)) continue;
            send_item(it);
            random_gap();
        end
    endtask

    // Hold off the receiver while the sender keeps going
    task automatic test_backpressure();
        long_hold_req++;
        for (int i = 0; i < 80; i++)
            send_item(query_item($urandom_range(0, 4095), $urandom_range(0, 4095) & 12'h00F));
        in_valid <= 1'b0;
        // pause until every result is in
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Receiver stall process
    always @(posedge clk) begin
        if (long_hold_req != long_hold_ack) begin
            long_hold_ack <= long_hold_req;
            hold_cycles <= 200;
            out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else if (!stall_enable) begin
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
            out_ready <= 1'b0;
            hold_cycles <= $urandom_range(5, 40);
        end else begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result x", out_data.out_x, -1);
            end else begin
                want = pending_results.pop_front();
                if (out_data.gray_out !== want.gray_out)
                    report_mismatch("gray_out", out_data.gray_out, want.gray_out);
                if (out_data.out_x !== want.out_x)
                    report_mismatch("out_x", out_data.out_x, want.out_x);
                if (out_data.out_y !== want.out_y)
                    report_mismatch("out_y", out_data.out_y, want.out_y);
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
            end
        end
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        for (int i = 0; i < 65536; i++) begin
            src_pix[i] = '0;
            pix_written[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(4, 3, 9, 7, 70);
        test_backpressure();
        test_random_phase(2, 5, 1, 4096, 70);
        test_random_phase(7, 1, 4096, 3, 70);
        stall_enable = 1'b0;
        test_random_phase(256, 2, 300, 13, 70);
        stall_enable = 1'b1;
        test_random_phase(5, 6, 4, 3, 70);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> bilinear_image_resizer_core.f
design/bir_pkg.sv
design/bilinear_image_resizer_core.sv
test/tb.sv
